// ===== rtl/core/dds_pkg.sv =====
// Shared types and constants for the dense shortest-path engine.
package dds_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VTX_W       = 6;
  localparam int WEIGHT_IN_W = 16;
  localparam int DIST_W      = 22;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_VC_W    = 7;
  localparam int CFG_SRC_W   = 6;

  localparam logic [DIST_W-1:0]   DIST_MAX   = '1;
  localparam logic [CFG_VC_W-1:0] VC_RESET   = 7'd64;
  localparam logic [CFG_SRC_W-1:0] SRC_RESET = 6'd0;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_SCAN,
    ST_PICK,
    ST_RELAX,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  typedef enum logic {
    UM_SCAN,
    UM_RELAX
  } unit_mode_t;

  typedef struct packed {
    logic              reach;
    logic [DIST_W-1:0] distance;
  } dist_ent_t;

  typedef struct packed {
    unit_mode_t mode;
    dist_ent_t  probe;
    dist_ent_t  best;
  } unit_req_t;

endpackage

// ===== rtl/core/dds_in_if.sv =====
// Input channel: matrix writes and run commands.
interface dds_in_if;
  import dds_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [VTX_W-1:0]       row;
  logic [VTX_W-1:0]       col;
  logic [WEIGHT_IN_W-1:0] weight;
  logic                   edge_present;

  modport source (output valid, cmd, row, col, weight, edge_present, input ready);
  modport sink   (input valid, cmd, row, col, weight, edge_present, output ready);
endinterface

// ===== rtl/core/dds_out_if.sv =====
// Result channel: one distance beat per vertex.
interface dds_out_if;
  import dds_pkg::*;
  logic              valid;
  logic              ready;
  logic [VTX_W-1:0]  vertex;
  logic [DIST_W-1:0] distance;
  logic              reachable;
  logic              last;

  modport source (output valid, vertex, distance, reachable, last, input ready);
  modport sink   (input valid, vertex, distance, reachable, last, output ready);
endinterface

// ===== rtl/core/dds_cfg_if.sv =====
// Configuration write channel.
interface dds_cfg_if;
  import dds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/core/dds_unit.sv =====
// Shared add/compare unit: min-search compare and edge relaxation.
module dds_unit #(
  parameter int WEIGHT_BITS = dds_pkg::WEIGHT_BITS_DEF
) (
  input  dds_pkg::unit_req_t      req,
  input  logic [WEIGHT_BITS-1:0]  weight,
  output logic                    better,
  output dds_pkg::dist_ent_t      result
);
  import dds_pkg::*;
  localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] sat;
  dist_ent_t         a;
  dist_ent_t         b;

  always_comb begin
    sum = SUM_W'(req.best.distance) + SUM_W'(weight);
    sat = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    if (req.mode == UM_RELAX) begin
      a.reach    = 1'b1;
      a.distance = sat;
      b          = req.probe;
    end else begin
      a = req.probe;
      b = req.best;
    end
    better = a.reach && (!b.reach || (a.distance < b.distance));
    result = a;
  end
endmodule

// ===== rtl/core/dense_dijkstra_shortest_paths.sv =====
// Dense single-source shortest-path engine over an adjacency-matrix RAM.
// Matrix writes are accepted while idle. Run over n vertices: n rounds, each a
// min scan plus a relaxation pass when the picked vertex is reachable, then
// one result beat per vertex via the read, load and wait states.
// One distance RAM read port and one add/compare unit set the pace.
// Reset returns control state and config to defaults; the matrix is undefined until written.
module dense_dijkstra_shortest_paths #(
  parameter int MAX_VERTICES = dds_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = dds_pkg::WEIGHT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dds_in_if.sink    in_bus,
  dds_out_if.source out_bus,
  dds_cfg_if.sink   cfg_bus
);
  import dds_pkg::*;

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int NW     = $clog2(MAX_VERTICES + 1);
  localparam int MW     = WEIGHT_BITS + 1;
  localparam int MDEPTH = 1 << (2 * VW);

  state_t               state_r, state_nxt;
  logic [CFG_VC_W-1:0]  vc_r;
  logic [CFG_SRC_W-1:0] src_r;
  logic [NW-1:0]        n_r, n_cur, round_r, ix_r;
  logic [VW-1:0]        nl_r, pix_r, u_r;
  logic                 pv_r, found_r;
  dist_ent_t            best_r;
  logic [MAX_VERTICES-1:0] visited_r, reach_r;

  logic                 out_valid_r, out_reach_r, out_last_r;
  logic [VTX_W-1:0]     out_vertex_r;
  logic [DIST_W-1:0]    out_dist_r;

  logic in_fire, cfg_fire, run_go, wr_go, src_ok, in_rdy, issue, pix_last;
  logic relax_upd, take;

  logic              dr_we;
  logic [VW-1:0]     dr_waddr;
  logic [DIST_W-1:0] dr_wdata, dr_rdata;
  logic [MW-1:0]     mw_rdata;

  unit_req_t unit_req;
  logic      unit_better;
  dist_ent_t unit_res;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;
  assign cfg_bus.ready = 1'b1;

  assign n_cur  = (32'(vc_r) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_r);
  assign src_ok = 32'(src_r) < 32'(n_cur);
  assign run_go = in_fire && (in_bus.cmd == CMD_RUN) && (n_cur != '0);
  assign wr_go  = in_fire && (in_bus.cmd == CMD_WRITE) &&
                  (32'(in_bus.row) < 32'(MAX_VERTICES)) &&
                  (32'(in_bus.col) < 32'(MAX_VERTICES));
  assign pix_last = pv_r && (pix_r == nl_r);

  dds_ram #(
    .WIDTH (MW),
    .DEPTH (MDEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (wr_go),
    .waddr ({VW'(in_bus.row), VW'(in_bus.col)}),
    .wdata ({in_bus.edge_present, WEIGHT_BITS'(in_bus.weight)}),
    .raddr ({u_r, ix_r[VW-1:0]}),
    .rdata (mw_rdata)
  );

  dds_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist (
    .clk   (clk),
    .we    (dr_we),
    .waddr (dr_waddr),
    .wdata (dr_wdata),
    .raddr (ix_r[VW-1:0]),
    .rdata (dr_rdata)
  );

  always_comb begin
    unit_req.mode           = (state_r == ST_RELAX) ? UM_RELAX : UM_SCAN;
    unit_req.probe.reach    = reach_r[pix_r];
    unit_req.probe.distance = dr_rdata;
    unit_req.best           = best_r;
  end

  dds_unit #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_unit (
    .req    (unit_req),
    .weight (mw_rdata[WEIGHT_BITS-1:0]),
    .better (unit_better),
    .result (unit_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (run_go) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_nxt = (round_r == n_r) ? ST_EMIT_RD : ST_SCAN;
      end
      ST_SCAN: begin
        if (pix_last) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        state_nxt = best_r.reach ? ST_RELAX : ST_NEXT;
      end
      ST_RELAX: begin
        if (pix_last) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_bus.ready) begin
          state_nxt = out_last_r ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_rdy    = 1'b0;
    issue     = 1'b0;
    relax_upd = 1'b0;
    take      = 1'b0;
    dr_we     = 1'b0;
    dr_waddr  = pix_r;
    dr_wdata  = unit_res.distance;
    case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (run_go && src_ok) begin
          dr_we    = 1'b1;
          dr_waddr = VW'(src_r);
          dr_wdata = '0;
        end
      end
      ST_SCAN: begin
        issue = (ix_r != n_r);
        take  = pv_r && !visited_r[pix_r] && (!found_r || unit_better);
      end
      ST_RELAX: begin
        issue     = (ix_r != n_r);
        relax_upd = pv_r && mw_rdata[MW-1] && !visited_r[pix_r] && unit_better;
        dr_we     = relax_upd;
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r  <= VC_RESET;
      src_r <= SRC_RESET;
    end else if (cfg_fire) begin
      if (cfg_bus.index == REG_VERTEX_COUNT) begin
        vc_r <= cfg_bus.data[CFG_VC_W-1:0];
      end else if (cfg_bus.index == REG_SOURCE_VERTEX) begin
        src_r <= cfg_bus.data[CFG_SRC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      visited_r   <= '0;
      reach_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;
      if (issue) begin
        pix_r <= ix_r[VW-1:0];
        ix_r  <= ix_r + NW'(1);
      end
      case (state_r)
        ST_IDLE: begin
          if (run_go) begin
            visited_r <= '0;
            reach_r   <= src_ok ? (MAX_VERTICES'(1) << src_r) : '0;
            round_r   <= '0;
            n_r       <= n_cur;
            nl_r      <= VW'(n_cur - NW'(1));
          end
        end
        ST_NEXT: begin
          ix_r    <= '0;
          found_r <= 1'b0;
        end
        ST_SCAN: begin
          if (take) begin
            u_r     <= pix_r;
            best_r  <= unit_res;
            found_r <= 1'b1;
          end
        end
        ST_PICK: begin
          visited_r[u_r] <= 1'b1;
          round_r        <= round_r + NW'(1);
          ix_r           <= '0;
        end
        ST_RELAX: begin
          if (relax_upd) begin
            reach_r[pix_r] <= 1'b1;
          end
        end
        ST_EMIT_LD: begin
          out_vertex_r <= VTX_W'(ix_r);
          out_reach_r  <= reach_r[ix_r[VW-1:0]];
          out_dist_r   <= reach_r[ix_r[VW-1:0]] ? dr_rdata : '0;
          out_last_r   <= (ix_r[VW-1:0] == nl_r);
          out_valid_r  <= 1'b1;
        end
        ST_EMIT_WAIT: begin
          if (out_bus.ready) begin
            out_valid_r <= 1'b0;
            ix_r        <= ix_r + NW'(1);
          end
        end
        default: begin
          out_valid_r <= out_valid_r;
        end
      endcase
    end
  end

  assign in_bus.ready      = in_rdy;
  assign out_bus.valid     = out_valid_r;
  assign out_bus.vertex    = out_vertex_r;
  assign out_bus.distance  = out_dist_r;
  assign out_bus.reachable = out_reach_r;
  assign out_bus.last      = out_last_r;

  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_bus.valid && in_bus.ready))
    else $error("input ready while a result beat is pending");

  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK) |-> (found_r && !visited_r[u_r]))
    else $error("pick without an unvisited candidate");

  a_relax_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (dr_we && (state_r == ST_RELAX)) |-> (dr_wdata >= best_r.distance))
    else $error("relaxed distance below the picked vertex distance");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.ready && out_bus.last) |=> in_bus.ready)
    else $error("engine not idle after the last result beat");

endmodule
